@@ src/qhd_pkg.sv @@
`default_nettype none

package qhd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 11;
  localparam int CFG_W        = 15;
  localparam int MODE_W       = 2;
  localparam int INDEX_W      = 2;
  localparam int BITS_W       = 6;
  localparam int COUNT_W      = 3;
  localparam int THERMO_W     = 7;
  localparam int LEVEL_W      = 3;

  // 6u needs three more bits than u
  localparam int UNIT_W = CFG_W + 3;
  localparam int CMP_W  = ((SAMPLE_WIDTH > UNIT_W) ? SAMPLE_WIDTH : UNIT_W) + 1;

  localparam logic [MODE_W-1:0] MODE_QPSK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QAM16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QAM64 = 2'd2;

  localparam logic [INDEX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_NORMALIZE = 2'd1;
  localparam logic [INDEX_W-1:0] REG_Q16_THR   = 2'd2;
  localparam logic [INDEX_W-1:0] REG_Q64_UNIT  = 2'd3;

  localparam logic [CFG_W-1:0] Q16_THR_RESET  = CFG_W'(1295);
  localparam logic [CFG_W-1:0] Q64_UNIT_RESET = CFG_W'(316);
  localparam logic [CFG_W-1:0] Q16_THR_FIXED  = CFG_W'(2 << FRAC_BITS);
  localparam logic [CFG_W-1:0] Q64_UNIT_FIXED = CFG_W'(1 << FRAC_BITS);

  localparam logic [COUNT_W-1:0] COUNT_QPSK  = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_QAM16 = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_QAM64 = 3'd6;
  localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;

  typedef struct packed {
    logic                pos;
    logic                big;
    logic [THERMO_W-1:0] thermo;
  } axis_dec_t;

  function automatic logic [LEVEL_W-1:0] level_count(input logic [THERMO_W-1:0] thermo);
    logic [LEVEL_W-1:0] n;
    n = '0;
    for (int k = 0; k < THERMO_W; k++) begin
      n = n + LEVEL_W'(thermo[k]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/qhd_slicer.sv @@
`default_nettype none

module qhd_slicer
  import qhd_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic        [CFG_W-1:0]        thr_i,
  input  wire logic        [UNIT_W-1:0]       u2_i,
  input  wire logic        [UNIT_W-1:0]       u4_i,
  input  wire logic        [UNIT_W-1:0]       u6_i,
  output axis_dec_t                           dec_o
);

  logic signed [CMP_W-1:0] x;
  logic signed [CMP_W-1:0] zero_s;
  logic signed [CMP_W-1:0] thr_p;
  logic signed [CMP_W-1:0] thr_n;
  logic signed [CMP_W-1:0] b2;
  logic signed [CMP_W-1:0] b4;
  logic signed [CMP_W-1:0] b6;
  axis_dec_t               dec_d;
  axis_dec_t               dec_q;

  always_comb begin
    x      = CMP_W'(sample_i);
    zero_s = signed'(CMP_W'(0));
    thr_p  = signed'(CMP_W'(thr_i));
    thr_n  = -thr_p;
    b2     = signed'(CMP_W'(u2_i));
    b4     = signed'(CMP_W'(u4_i));
    b6     = signed'(CMP_W'(u6_i));

    dec_d.pos       = x > zero_s;
    dec_d.big       = (x > thr_p) || (x < thr_n);
    dec_d.thermo[0] = x > -b6;
    dec_d.thermo[1] = x > -b4;
    dec_d.thermo[2] = x > -b2;
    dec_d.thermo[3] = x > zero_s;
    dec_d.thermo[4] = x > b2;
    dec_d.thermo[5] = x > b4;
    dec_d.thermo[6] = x > b6;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

`default_nettype wire

@@ src/qam_hard_decision_demapper.sv @@
// QAM hard-decision demapper: one complex symbol in, one set of decided bits out.
// Input channel: in_valid_i / in_stall_o with in_phase_i and quadrature_i, signed
// Q4.11 samples. Output channel: out_valid_o / out_stall_i with decided_bits_o
// (first decided bit highest among the used bits) and bit_count_o (2, 4 or 6;
// 0 for the unused mode code).
// Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is high
// (0 mode, 1 normalize, 2 16-QAM threshold, 3 64-QAM unit). Write only while idle.
// The block is a three-stage pipeline: input and threshold capture, per-axis
// compares, level count and packing into the output register. An accepted item
// passes through the stage-one, slicer and output registers in turn.
// Throughput is one item per cycle while the output is not stalled.
// When the receiver stalls, the output holds and empty stages still fill, so up
// to three items are held before in_stall_o rises; nothing is lost or repeated.
// Reset empties the pipeline and returns the registers to QPSK, no normalizing,
// threshold 1295 and unit 316.
`default_nettype none

module qam_hard_decision_demapper
  import qhd_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic        [INDEX_W-1:0]      cfg_index_i,
  input  wire logic        [CFG_W-1:0]        cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_phase_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] quadrature_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic             [BITS_W-1:0]       decided_bits_o,
  output logic             [COUNT_W-1:0]      bit_count_o
);

  logic [MODE_W-1:0] mode_q;
  logic              norm_q;
  logic [CFG_W-1:0]  q16_thr_q;
  logic [CFG_W-1:0]  q64_unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_QPSK;
      norm_q     <= 1'b0;
      q16_thr_q  <= Q16_THR_RESET;
      q64_unit_q <= Q64_UNIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:      mode_q     <= cfg_data_i[MODE_W-1:0];
        REG_NORMALIZE: norm_q     <= cfg_data_i[0];
        REG_Q16_THR:   q16_thr_q  <= cfg_data_i;
        REG_Q64_UNIT:  q64_unit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic ready1;
  logic ready2;
  logic ready3;
  logic v1_q;
  logic v2_q;
  logic v3_q;

  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  logic [CFG_W-1:0]  thr_d;
  logic [CFG_W-1:0]  unit_sel;
  logic [UNIT_W-1:0] u2_d;
  logic [UNIT_W-1:0] u4_d;
  logic [UNIT_W-1:0] u6_d;

  always_comb begin
    thr_d    = norm_q ? q16_thr_q : Q16_THR_FIXED;
    unit_sel = norm_q ? q64_unit_q : Q64_UNIT_FIXED;
    u2_d     = UNIT_W'(unit_sel) << 1;
    u4_d     = UNIT_W'(unit_sel) << 2;
    u6_d     = u2_d + u4_d;
  end

  logic signed [SAMPLE_WIDTH-1:0] i1_q;
  logic signed [SAMPLE_WIDTH-1:0] q1_q;
  logic        [MODE_W-1:0]       mode1_q;
  logic        [CFG_W-1:0]        thr1_q;
  logic        [UNIT_W-1:0]       u2_q;
  logic        [UNIT_W-1:0]       u4_q;
  logic        [UNIT_W-1:0]       u6_q;

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      i1_q    <= in_phase_i;
      q1_q    <= quadrature_i;
      mode1_q <= mode_q;
      thr1_q  <= thr_d;
      u2_q    <= u2_d;
      u4_q    <= u4_d;
      u6_q    <= u6_d;
    end
  end

  axis_dec_t         dec_re;
  axis_dec_t         dec_im;
  logic [MODE_W-1:0] mode2_q;

  qhd_slicer u_slicer_i (
    .clk_i    (clk_i),
    .en_i     (ready2),
    .sample_i (i1_q),
    .thr_i    (thr1_q),
    .u2_i     (u2_q),
    .u4_i     (u4_q),
    .u6_i     (u6_q),
    .dec_o    (dec_re)
  );

  qhd_slicer u_slicer_q (
    .clk_i    (clk_i),
    .en_i     (ready2),
    .sample_i (q1_q),
    .thr_i    (thr1_q),
    .u2_i     (u2_q),
    .u4_i     (u4_q),
    .u6_i     (u6_q),
    .dec_o    (dec_im)
  );

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      mode2_q <= mode1_q;
    end
  end

  logic [BITS_W-1:0]  bits_d;
  logic [COUNT_W-1:0] count_d;
  logic [BITS_W-1:0]  bits_q;
  logic [COUNT_W-1:0] count_q;

  always_comb begin
    case (mode2_q)
      MODE_QPSK: begin
        bits_d  = {4'b0000, dec_re.pos, dec_im.pos};
        count_d = COUNT_QPSK;
      end
      MODE_QAM16: begin
        bits_d  = {2'b00, dec_re.pos, dec_re.big, dec_im.pos, dec_im.big};
        count_d = COUNT_QAM16;
      end
      MODE_QAM64: begin
        bits_d  = {level_count(dec_re.thermo), level_count(dec_im.thermo)};
        count_d = COUNT_QAM64;
      end
      default: begin
        bits_d  = '0;
        count_d = COUNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready3) begin
      bits_q  <= bits_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o    = v3_q;
  assign decided_bits_o = bits_q;
  assign bit_count_o    = count_q;

endmodule

`default_nettype wire

@@ dv/qam_hard_decision_demapper_tb.sv @@
`default_nettype none

module qam_hard_decision_demapper_tb;
  import qhd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] count;
  } decision_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic        [INDEX_W-1:0]      cfg_index_i;
  logic        [CFG_W-1:0]        cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] in_phase_i;
  logic signed [SAMPLE_WIDTH-1:0] quadrature_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic        [BITS_W-1:0]       decided_bits_o;
  logic        [COUNT_W-1:0]      bit_count_o;

  logic [MODE_W-1:0] cur_mode;
  logic              cur_normalize;
  logic [CFG_W-1:0]  cur_threshold;
  logic [CFG_W-1:0]  cur_unit;

  decision_t pending_q[$];
  int        mismatch_count;
  int        cycle_count;

  bit idle_on;
  int gap_max;
  int burst_left;

  int stall_style;
  int stall_pct;
  int hold_request;
  int hold_left;
  int run_left;
  bit run_stall;

  qam_hard_decision_demapper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_phase_i    (in_phase_i),
    .quadrature_i  (quadrature_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .decided_bits_o(decided_bits_o),
    .bit_count_o   (bit_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [LEVEL_W-1:0] axis_level(input int v, input int unit);
    logic [LEVEL_W-1:0] n;
    n = '0;
    for (int k = -3; k <= 3; k++) begin
      if (v > 2 * k * unit) n = n + 1'b1;
    end
    return n;
  endfunction

  function automatic decision_t decide_symbol(input logic signed [SAMPLE_WIDTH-1:0] i_s,
                                              input logic signed [SAMPLE_WIDTH-1:0] q_s);
    decision_t d;
    int iv;
    int qv;
    int i_mag;
    int q_mag;
    int thr;
    int unit;
    iv    = i_s;
    qv    = q_s;
    i_mag = (iv < 0) ? -iv : iv;
    q_mag = (qv < 0) ? -qv : qv;
    thr   = cur_normalize ? int'(cur_threshold) : int'(Q16_THR_FIXED);
    unit  = cur_normalize ? int'(cur_unit) : int'(Q64_UNIT_FIXED);
    case (cur_mode)
      MODE_QPSK: begin
        d.bits  = {4'b0000, iv > 0, qv > 0};
        d.count = COUNT_QPSK;
      end
      MODE_QAM16: begin
        d.bits  = {2'b00, iv > 0, i_mag > thr, qv > 0, q_mag > thr};
        d.count = COUNT_QAM16;
      end
      MODE_QAM64: begin
        d.bits  = {axis_level(iv, unit), axis_level(qv, unit)};
        d.count = COUNT_QAM64;
      end
      default: begin
        d.bits  = '0;
        d.count = COUNT_NONE;
      end
    endcase
    return d;
  endfunction

  function automatic int decision_step();
    if (cur_mode == MODE_QAM16) begin
      return cur_normalize ? int'(cur_threshold) : int'(Q16_THR_FIXED);
    end
    return 2 * (cur_normalize ? int'(cur_unit) : int'(Q64_UNIT_FIXED));
  endfunction

  function automatic int draw_sample(input int step);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = (int'($urandom_range(0, 6)) - 3) * step + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom_range(0, 64)) - 32;
      default: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH %s: got %0d, want %0d, cycle %0d", what, got, want, cycle_count);
    end
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    case (idx)
      REG_MODE:      cur_mode      = MODE_W'(value);
      REG_NORMALIZE: cur_normalize = value[0];
      REG_Q16_THR:   cur_threshold = CFG_W'(value);
      default:       cur_unit      = CFG_W'(value);
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_config();
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_symbol(input int i_v, input int q_v);
    int gap;
    in_valid_i   <= 1'b1;
    in_phase_i   <= SAMPLE_WIDTH'(i_v);
    quadrature_i <= SAMPLE_WIDTH'(q_v);
    do @(posedge clk_i); while (in_stall_o);
    pending_q.insert(pending_q.size(),
                     decide_symbol(SAMPLE_WIDTH'(i_v), SAMPLE_WIDTH'(q_v)));
    if (idle_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: long hold-off on request, otherwise no stall or runs of stall and accept, by stall style
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_style == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 99) < stall_pct);
          run_left  = $urandom_range(1, 6);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", decided_bits_o, 0);
      end else begin
        want = pending_q.pop_front();
        if (decided_bits_o !== want.bits) begin
          report_mismatch("decided_bits", decided_bits_o, want.bits);
        end
        if (bit_count_o !== want.count) begin
          report_mismatch("bit_count", bit_count_o, want.count);
        end
      end
    end
  end

  task automatic test_reset_values();
    write_reg(REG_MODE, MODE_QAM16);
    write_reg(REG_NORMALIZE, 1);
    end_config();
    send_symbol(1295, -1295);
    send_symbol(1296, -1296);
    wait_idle();
    write_reg(REG_MODE, MODE_QAM64);
    end_config();
    send_symbol(632, 633);
    send_symbol(-632, -633);
    send_symbol(1896, 1897);
    wait_idle();
  endtask

  task automatic test_qpsk();
    write_reg(REG_MODE, MODE_QPSK);
    write_reg(REG_NORMALIZE, 0);
    end_config();
    send_symbol(0, 0);
    send_symbol(1, -1);
    send_symbol(-1, 1);
    send_symbol(32767, -32768);
    wait_idle();
  endtask

  task automatic test_qam16_fixed();
    write_reg(REG_MODE, MODE_QAM16);
    end_config();
    send_symbol(4096, -4096);
    send_symbol(4097, -4097);
    send_symbol(-32768, 32767);
    wait_idle();
  endtask

  task automatic test_qam64_fixed();
    write_reg(REG_MODE, MODE_QAM64);
    end_config();
    send_symbol(0, -1);
    send_symbol(4096, 4097);
    send_symbol(-4096, -4095);
    send_symbol(-12288, -12287);
    send_symbol(32767, -32768);
    wait_idle();
  endtask

  task automatic test_zero_thresholds();
    write_reg(REG_MODE, MODE_QAM16);
    write_reg(REG_NORMALIZE, 1);
    write_reg(REG_Q16_THR, 0);
    write_reg(REG_Q64_UNIT, 0);
    end_config();
    send_symbol(0, 1);
    send_symbol(-1, -32768);
    wait_idle();
    write_reg(REG_MODE, MODE_QAM64);
    end_config();
    send_symbol(0, 1);
    send_symbol(-1, 32767);
    wait_idle();
  endtask

  task automatic test_max_thresholds();
    write_reg(REG_MODE, MODE_QAM16);
    write_reg(REG_Q16_THR, 32767);
    write_reg(REG_Q64_UNIT, 32767);
    end_config();
    send_symbol(32767, -32768);
    wait_idle();
    write_reg(REG_MODE, MODE_QAM64);
    end_config();
    send_symbol(-32768, 32767);
    send_symbol(-1, 1);
    wait_idle();
  endtask

  task automatic test_unused_mode();
    write_reg(REG_MODE, MODE_UNUSED);
    end_config();
    send_symbol(1, 1);
    send_symbol(-32768, 32767);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, MODE_QAM64);
    write_reg(REG_NORMALIZE, 0);
    end_config();
    idle_on      = 1'b0;
    hold_request = 300;
    for (int n = 0; n < 40; n++) begin
      send_symbol(draw_sample(decision_step()), draw_sample(decision_step()));
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 10; phase++) begin
      int mode_v;
      int norm_v;
      int thr_v;
      int unit_v;
      if ($urandom_range(0, 11) == 0) mode_v = MODE_UNUSED;
      else mode_v = $urandom_range(0, 2);
      norm_v = $urandom_range(0, 1);
      case (phase)
        0: begin
          thr_v  = 0;
          unit_v = 0;
          norm_v = 1;
        end
        1: begin
          thr_v  = 32767;
          unit_v = 32767;
          norm_v = 1;
        end
        default: begin
          thr_v  = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(1, 3000);
          unit_v = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(1, 1000);
        end
      endcase
      write_reg(REG_MODE, mode_v);
      write_reg(REG_NORMALIZE, norm_v);
      write_reg(REG_Q16_THR, thr_v);
      write_reg(REG_Q64_UNIT, unit_v);
      end_config();
      if (phase == 2) begin
        idle_on     = 1'b0;
        stall_style = 0;
      end else begin
        idle_on     = ($urandom_range(0, 3) != 0);
        gap_max     = $urandom_range(1, 8);
        stall_style = ($urandom_range(0, 3) != 0);
        stall_pct   = $urandom_range(10, 70);
      end
      for (int n = 0; n < 100; n++) begin
        send_symbol(draw_sample(decision_step()), draw_sample(decision_step()));
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_phase_i     = '0;
    quadrature_i   = '0;
    cur_mode       = MODE_QPSK;
    cur_normalize  = 1'b0;
    cur_threshold  = Q16_THR_RESET;
    cur_unit       = Q64_UNIT_RESET;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;
    gap_max        = 4;
    burst_left     = 0;
    stall_style    = 1;
    stall_pct      = 30;
    hold_request   = 0;
    hold_left      = 0;
    run_left       = 0;
    run_stall      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_qpsk();
    test_qam16_fixed();
    test_qam64_fixed();
    test_zero_thresholds();
    test_max_thresholds();
    test_unused_mode();
    test_backpressure();
    test_random_phases();

    repeat (10) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      report_mismatch("results still pending", pending_q.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/qhd_pkg.sv
src/qhd_slicer.sv
src/qam_hard_decision_demapper.sv
dv/qam_hard_decision_demapper_tb.sv
